// ----- rtl/cmwc_pkg.sv -----
`timescale 1ns / 1ps

package cmwc_pkg;

    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int MULT_W = 15;
    localparam int PROD_W = WORD_W + MULT_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MULT_W-1:0] CMWC_MULT  = 15'd18705;
    localparam logic [WORD_W-1:0] CMWC_TOP   = 32'hffff_fffe;
    localparam logic [WORD_W-1:0] CARRY_INIT = 32'd362436;
    localparam logic [WORD_W-1:0] GOLDEN     = 32'h9e37_79b9;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_RAW     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOUNDED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESEED  = 2'd2;

    // Commands handed from the front to the back
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_RAW  = 2'd0;
    localparam logic [OP_W-1:0] OP_MOD  = 2'd1;
    localparam logic [OP_W-1:0] OP_ERR  = 2'd2;
    localparam logic [OP_W-1:0] OP_FILL = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] arg_a;   // seed for a refill, lower bound for a bounded draw
        logic [WORD_W-1:0] arg_b;   // span of the bounded range
    } cmd_t;

endpackage

// ----- rtl/cmwc_front.sv -----
`timescale 1ns / 1ps

module cmwc_front
(
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cmwc_pkg::MODE_W-1:0]        mode,
    input  logic [cmwc_pkg::WORD_W-1:0]        seed_value,
    input  logic [cmwc_pkg::WORD_W-1:0]        range_low,
    input  logic [cmwc_pkg::WORD_W-1:0]        range_high,
    output logic                               push,
    output cmwc_pkg::cmd_t                     push_cmd,
    input  logic                               queue_full
);

    logic keep;

    // Classify the item; an unused mode is taken and dropped.
    always_comb
    begin
        keep           = 1'b1;
        push_cmd.op    = cmwc_pkg::OP_RAW;
        push_cmd.arg_a = range_low;
        push_cmd.arg_b = range_high - range_low;
        case (mode)
            cmwc_pkg::MODE_RAW:
            begin
                push_cmd.op = cmwc_pkg::OP_RAW;
            end
            cmwc_pkg::MODE_BOUNDED:
            begin
                if (range_high <= range_low)
                begin
                    push_cmd.op = cmwc_pkg::OP_ERR;
                end
                else
                begin
                    push_cmd.op = cmwc_pkg::OP_MOD;
                end
            end
            cmwc_pkg::MODE_RESEED:
            begin
                push_cmd.op    = cmwc_pkg::OP_FILL;
                push_cmd.arg_a = seed_value;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full && keep;

endmodule

// ----- rtl/cmwc_queue.sv -----
`timescale 1ns / 1ps

module cmwc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cmwc_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           q_valid,
    output cmwc_pkg::cmd_t q_cmd,
    input  logic           pop
);

    localparam logic [cmwc_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        cmwc_pkg::QUEUE_CNT_W'(cmwc_pkg::QUEUE_DEPTH);
    localparam logic [cmwc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        cmwc_pkg::QUEUE_PTR_W'(cmwc_pkg::QUEUE_DEPTH - 1);

    cmwc_pkg::cmd_t                     slot_reg [cmwc_pkg::QUEUE_DEPTH];
    logic [cmwc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [cmwc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [cmwc_pkg::QUEUE_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/cmwc_divider.sv -----
`timescale 1ns / 1ps

// Restoring remainder unit, one quotient bit per cycle.
module cmwc_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cmwc_pkg::WORD_W-1:0] dividend,
    input  logic [cmwc_pkg::WORD_W-1:0] divisor,
    output logic                        done,
    output logic [cmwc_pkg::WORD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(cmwc_pkg::WORD_W + 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [cmwc_pkg::WORD_W-1:0]  rem_reg, rem_next;
    logic [cmwc_pkg::WORD_W-1:0]  dvd_reg, dvd_next;
    logic [cmwc_pkg::WORD_W-1:0]  dvs_reg, dvs_next;
    logic [cmwc_pkg::WORD_W:0]    shifted;

    assign shifted = {rem_reg, dvd_reg[cmwc_pkg::WORD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(cmwc_pkg::WORD_W);
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = cmwc_pkg::WORD_W'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = shifted[cmwc_pkg::WORD_W-1:0];
            end
            dvd_next = {dvd_reg[cmwc_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/cmwc_back.sv -----
`timescale 1ns / 1ps

module cmwc_back
#(
    parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  cmwc_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cmwc_pkg::WORD_W-1:0] value,
    output logic                        range_error
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_FILL = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd1;
    localparam logic [ST_W-1:0] ST_MUL  = 3'd2;
    localparam logic [ST_W-1:0] ST_CALC = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
    localparam logic [ST_W-1:0] ST_EMIT = 3'd5;

    logic [cmwc_pkg::WORD_W-1:0] lag_mem [TABLE_DEPTH];

    logic [ST_W-1:0]              state_reg, state_next;
    logic [IDX_W-1:0]             fill_idx_reg, fill_idx_next;
    logic [cmwc_pkg::WORD_W-1:0]  fill_seed_reg, fill_seed_next;
    logic [cmwc_pkg::WORD_W-1:0]  e_m1_reg, e_m1_next;
    logic [cmwc_pkg::WORD_W-1:0]  e_m2_reg, e_m2_next;
    logic [cmwc_pkg::WORD_W-1:0]  e_m3_reg, e_m3_next;
    logic [cmwc_pkg::WORD_W-1:0]  carry_reg, carry_next;
    logic [IDX_W-1:0]             index_reg, index_next;
    logic [cmwc_pkg::OP_W-1:0]    op_reg, op_next;
    logic [cmwc_pkg::WORD_W-1:0]  low_reg, low_next;
    logic [cmwc_pkg::WORD_W-1:0]  span_reg, span_next;
    logic [cmwc_pkg::PROD_W-1:0]  prod_reg;
    logic [cmwc_pkg::WORD_W-1:0]  rd_data_reg;
    logic [cmwc_pkg::WORD_W-1:0]  word_reg, word_next;
    logic                         err_reg, err_next;
    logic                         out_valid_reg, out_valid_next;
    logic [cmwc_pkg::WORD_W-1:0]  out_value_reg, out_value_next;
    logic                         out_err_reg, out_err_next;

    logic [IDX_W-1:0]             nxt_idx;
    logic [cmwc_pkg::WORD_W-1:0]  fill_word;
    logic [cmwc_pkg::SUM_W-1:0]   t_sum;
    logic [cmwc_pkg::WORD_W-1:0]  drawn;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [cmwc_pkg::WORD_W-1:0]  wr_data;
    logic                         div_start;
    logic                         div_done;
    logic [cmwc_pkg::WORD_W-1:0]  div_rem;

    assign nxt_idx = (index_reg == LAST_IDX) ? '0 : index_reg + 1'b1;
    assign t_sum   = cmwc_pkg::SUM_W'(prod_reg) + cmwc_pkg::SUM_W'(carry_reg);
    assign drawn   = cmwc_pkg::CMWC_TOP - t_sum[cmwc_pkg::WORD_W-1:0];

    always_comb
    begin
        if (fill_idx_reg == IDX_W'(0))
        begin
            fill_word = fill_seed_reg;
        end
        else if (fill_idx_reg == IDX_W'(1))
        begin
            fill_word = fill_seed_reg + cmwc_pkg::GOLDEN;
        end
        else if (fill_idx_reg == IDX_W'(2))
        begin
            fill_word = fill_seed_reg + cmwc_pkg::GOLDEN + cmwc_pkg::GOLDEN;
        end
        else
        begin
            fill_word = e_m3_reg ^ e_m2_reg ^ cmwc_pkg::GOLDEN
                      ^ cmwc_pkg::WORD_W'(fill_idx_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_idx_next  = fill_idx_reg;
        fill_seed_next = fill_seed_reg;
        e_m1_next      = e_m1_reg;
        e_m2_next      = e_m2_reg;
        e_m3_next      = e_m3_reg;
        carry_next     = carry_reg;
        index_next     = index_reg;
        op_next        = op_reg;
        low_next       = low_reg;
        span_next      = span_reg;
        word_next      = word_reg;
        err_next       = err_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = index_reg;
        wr_data        = drawn;
        div_start      = 1'b0;

        case (state_reg)
            ST_FILL:
            begin
                wr_en     = 1'b1;
                wr_addr   = fill_idx_reg;
                wr_data   = fill_word;
                e_m3_next = e_m2_reg;
                e_m2_next = e_m1_reg;
                e_m1_next = fill_word;
                if (fill_idx_reg == LAST_IDX)
                begin
                    carry_next = cmwc_pkg::CARRY_INIT;
                    index_next = LAST_IDX;
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_cmd.op;
                    low_next  = q_cmd.arg_a;
                    span_next = q_cmd.arg_b;
                    case (q_cmd.op)
                        cmwc_pkg::OP_RAW, cmwc_pkg::OP_MOD:
                        begin
                            index_next = nxt_idx;
                            state_next = ST_MUL;
                        end
                        cmwc_pkg::OP_ERR:
                        begin
                            word_next  = '0;
                            err_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            fill_seed_next = q_cmd.arg_a;
                            fill_idx_next  = '0;
                            state_next     = ST_FILL;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                wr_en      = 1'b1;
                carry_next = cmwc_pkg::WORD_W'(t_sum >> cmwc_pkg::WORD_W);
                err_next   = 1'b0;
                if (op_reg == cmwc_pkg::OP_MOD)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    word_next  = drawn;
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    word_next  = div_rem + low_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = word_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    cmwc_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (drawn),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Lag table: one write port, one registered read of the next entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lag_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= lag_mem[nxt_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_idx_reg  <= '0;
            fill_seed_reg <= '0;
            carry_reg     <= cmwc_pkg::CARRY_INIT;
            index_reg     <= LAST_IDX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_idx_reg  <= fill_idx_next;
            fill_seed_reg <= fill_seed_next;
            carry_reg     <= carry_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_m1_reg      <= e_m1_next;
        e_m2_reg      <= e_m2_next;
        e_m3_reg      <= e_m3_next;
        op_reg        <= op_next;
        low_reg       <= low_next;
        span_reg      <= span_next;
        prod_reg      <= cmwc_pkg::PROD_W'(cmwc_pkg::CMWC_MULT)
                       * cmwc_pkg::PROD_W'(rd_data_reg);
        word_reg      <= word_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid   = out_valid_reg;
    assign value       = out_value_reg;
    assign range_error = out_err_reg;

    a_no_pop_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> !q_pop)
        else $error("command taken while the table is being filled");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside the divide step");

    a_fill_end_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && fill_idx_reg == LAST_IDX)
            |=> (carry_reg == cmwc_pkg::CARRY_INIT && index_reg == LAST_IDX))
        else $error("carry or index not restored after a table fill");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= LAST_IDX)
        else $error("table index beyond the table");

    a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_value_reg == '0))
        else $error("range error result with a nonzero value");

endmodule

// ----- rtl/cmwc_random_generator.sv -----
`timescale 1ns / 1ps

// Complementary multiply-with-carry random source with a lag table of TABLE_DEPTH
// words. Each transfer on the input carries a mode: raw (one 32-bit draw), bounded
// (draw mod (range_high - range_low) + range_low, or value 0 with range_error set
// and no draw when range_high is not above range_low), or reseed (refill the table
// from seed_value, no result). Mode 3 is taken and dropped. Items pass through a
// two-entry command queue, so the input keeps accepting while the generator works.
// Timing is set by the table read-modify-write and the one-bit-per-cycle
// remainder unit: a raw draw steps through pop, multiply, write back and result,
// a bounded draw adds 32 remainder steps before the result, a range error goes
// from pop straight to result, and a reseed writes one table entry per cycle. After
// reset the table of TABLE_DEPTH words (4096 by default) is filled from seed 0;
// up to two items are accepted into the queue in that time, then stall rises until
// the fill ends. A finished result sits in an output register, so a stalled output
// holds only one result while the next command is already being worked.
module cmwc_random_generator
#(
    parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cmwc_pkg::MODE_W-1:0] mode,
    input  logic [cmwc_pkg::WORD_W-1:0] seed_value,
    input  logic [cmwc_pkg::WORD_W-1:0] range_low,
    input  logic [cmwc_pkg::WORD_W-1:0] range_high,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cmwc_pkg::WORD_W-1:0] value,
    output logic                        range_error
);

    logic           push;
    cmwc_pkg::cmd_t push_cmd;
    logic           queue_full;
    logic           q_valid;
    cmwc_pkg::cmd_t q_cmd;
    logic           q_pop;

    // Classify each transfer and precompute the range span.
    cmwc_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .seed_value (seed_value),
        .range_low  (range_low),
        .range_high (range_high),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // Hold commands until the generator is free.
    cmwc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (q_pop)
    );

    // Table, carry, fill sequencer and result register.
    cmwc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .range_error (range_error)
    );

endmodule

// ----- dv/tb_cmwc_random_generator.sv -----
`timescale 1ns / 1ps

module tb_cmwc_random_generator;

    localparam int WORD_W = cmwc_pkg::WORD_W;
    localparam int MODE_W = cmwc_pkg::MODE_W;
    localparam logic [cmwc_pkg::MULT_W-1:0] CMWC_MULT = cmwc_pkg::CMWC_MULT;
    localparam logic [WORD_W-1:0] CMWC_TOP   = cmwc_pkg::CMWC_TOP;
    localparam logic [WORD_W-1:0] CARRY_INIT = cmwc_pkg::CARRY_INIT;
    localparam logic [WORD_W-1:0] GOLDEN     = cmwc_pkg::GOLDEN;
    localparam logic [MODE_W-1:0] MODE_RAW     = cmwc_pkg::MODE_RAW;
    localparam logic [MODE_W-1:0] MODE_BOUNDED = cmwc_pkg::MODE_BOUNDED;
    localparam logic [MODE_W-1:0] MODE_RESEED  = cmwc_pkg::MODE_RESEED;

    localparam int TBL_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Idle cycles allowed with no transfer on either side. The slowest stretch is the
    // fill after reset followed at once by a queued reseed, plus a receiver hold-off.
    localparam int IDLE_LIMIT   = 6 * TBL_DEPTH + 4000;
    // Cycles to keep watching after the last expected result; a reseed may still run.
    localparam int TAIL_CYCLES  = TBL_DEPTH + 64;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLDOFF_LEN  = 500;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
    } stim_item_t;

    typedef struct {
        logic [WORD_W-1:0] value;
        logic              range_error;
    } draw_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [MODE_W-1:0] mode = MODE_RAW;
    logic [WORD_W-1:0] seed_value = '0;
    logic [WORD_W-1:0] range_low = '0;
    logic [WORD_W-1:0] range_high = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [WORD_W-1:0] value;
    logic              range_error;

    // Stimulus waiting to be offered, and results the generator still owes us
    stim_item_t   pending_items[$];
    draw_result_t expected_draws[$];

    // Shadow copy of the generator state
    logic [WORD_W-1:0] lag_mem [TBL_DEPTH];
    logic [WORD_W-1:0] lag_carry;
    logic [11:0]       lag_pos;

    int sent_count = 0;
    int err_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int holdoff_left = 0;
    int next_holdoff = 300;
    logic [7:0] stall_tick = '0;

    always #4 clk = ~clk;

    cmwc_random_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .seed_value  (seed_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .range_error (range_error)
    );

    // Refill the shadow table from a seed: three golden-ratio steps, then each entry
    // mixes the entries three and two back with the constant and its own index.
    function automatic void reseed_lag_table(logic [WORD_W-1:0] seed);
        lag_mem[0] = seed;
        lag_mem[1] = seed + GOLDEN;
        lag_mem[2] = seed + GOLDEN + GOLDEN;
        for (int i = 3; i < TBL_DEPTH; i++)
        begin
            lag_mem[i] = lag_mem[i-3] ^ lag_mem[i-2] ^ GOLDEN ^ i;
        end
        lag_carry = CARRY_INIT;
        lag_pos   = 12'(TBL_DEPTH - 1);
    endfunction

    // Advance the index (wrap after the last entry), form 18705 * entry + carry over
    // 64 bits, keep the high half as carry and store 0xfffffffe minus the low half.
    function automatic logic [WORD_W-1:0] next_cmwc_word();
        logic [63:0]       prod;
        logic [WORD_W-1:0] word;
        int                nxt;
        nxt = (int'(lag_pos) == TBL_DEPTH - 1) ? 0 : int'(lag_pos) + 1;
        lag_pos = 12'(nxt);
        prod = {32'd0, lag_mem[nxt]} * {49'd0, CMWC_MULT} + {32'd0, lag_carry};
        lag_carry = prod[63:32];
        word = CMWC_TOP - prod[31:0];
        lag_mem[nxt] = word;
        return word;
    endfunction

    // Work out what one accepted transfer owes on the output, if anything
    function automatic void predict_transfer(stim_item_t it);
        draw_result_t res;
        logic [WORD_W-1:0] word;
        case (it.mode)
            MODE_RAW:
            begin
                res.value = next_cmwc_word();
                res.range_error = 1'b0;
                expected_draws.push_back(res);
            end
            MODE_BOUNDED:
            begin
                // Empty range: flag it, return 0 and leave the state alone
                if (it.high <= it.low)
                begin
                    res.value = '0;
                    res.range_error = 1'b1;
                end
                else
                begin
                    word = next_cmwc_word();
                    res.value = (word % (it.high - it.low)) + it.low;
                    res.range_error = 1'b0;
                end
                expected_draws.push_back(res);
            end
            MODE_RESEED:
            begin
                reseed_lag_table(it.seed);
            end
            default:
            begin
                // Unused selector: taken and dropped
            end
        endcase
    endfunction

    function automatic void add_item(logic [MODE_W-1:0] m, logic [WORD_W-1:0] s,
                                     logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
        stim_item_t it;
        it.mode = m;
        it.seed = s;
        it.low  = lo;
        it.high = hi;
        pending_items.push_back(it);
    endfunction

    // Sender: offer items in bursts of random length with random gaps between them.
    // Hold the payload while stalled; only pick a new item once the current one
    // has transferred or nothing is on offer.
    always @(posedge clk)
    begin
        stim_item_t cur;
        stim_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cur.mode = mode;
                cur.seed = seed_value;
                cur.low  = range_low;
                cur.high = range_high;
                predict_transfer(cur);
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    mode       <= nxt.mode;
                    seed_value <= nxt.seed;
                    range_low  <= nxt.low;
                    range_high <= nxt.high;
                    in_valid   <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // Start a new burst; a quarter of them follow back to back
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a pattern that walks through four segments
    // (no stall, heavy random, periodic, light random). Twice during the run hold off
    // for a long stretch while the sender keeps offering, so the command queue and
    // output register fill up and in_stall has to rise.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_stall <= 1'b1;
        end
        else if (sent_count >= next_holdoff)
        begin
            holdoff_left <= HOLDOFF_LEN;
            next_holdoff <= next_holdoff + 600;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_tick <= stall_tick + 8'd1;
            case (stall_tick[7:6])
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 1) == 0);
                2'd2: out_stall <= (stall_tick[1:0] == 2'b11);
                default: out_stall <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        draw_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual value %h range_error %b",
                         $time, value, range_error);
                err_count++;
            end
            else
            begin
                exp_res = expected_draws.pop_front();
                if (value !== exp_res.value)
                begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, exp_res.value, value);
                    err_count++;
                end
                if (range_error !== exp_res.range_error)
                begin
                    $display("%0t: range_error mismatch, expected %b actual %b",
                             $time, exp_res.range_error, range_error);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing transfers on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int counted;
        int pick;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;

        // The block fills its table from seed 0 on reset; mirror that
        reseed_lag_table('0);

        // Directed: field extremes, every mode, empty ranges, the unused selector
        add_item(MODE_RAW,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_RAW,     32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'hffff_fffe, 32'hffff_ffff);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0005, 32'h0000_0005);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_BOUNDED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
        add_item(MODE_UNUSED,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_item(MODE_RAW,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_RESEED,  32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_RAW,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h8000_0000, 32'hffff_ffff);
        add_item(MODE_RESEED,  32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
        add_item(MODE_RAW,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0001, 32'h0000_0003);
        add_item(MODE_RESEED,  32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
        add_item(MODE_UNUSED,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        // Raw mode ignores an empty range in the bound fields
        add_item(MODE_RAW,     32'h0000_0000, 32'h0000_0009, 32'h0000_0002);
        add_item(MODE_BOUNDED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0002);

        // Random: mostly draws, a few reseeds and dropped selectors
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                add_item(MODE_RESEED, $urandom, $urandom, $urandom);
                counted++;
            end
            else if (pick < 5)
            begin
                add_item(MODE_UNUSED, $urandom, $urandom, $urandom);
            end
            else if (pick < 50)
            begin
                add_item(MODE_RAW, $urandom, $urandom, $urandom);
                counted++;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        // Fully random bounds; about half are empty ranges
                        lo = $urandom;
                        hi = $urandom;
                    end
                    1:
                    begin
                        // Narrow span near zero
                        lo = $urandom_range(0, 1000);
                        hi = lo + $urandom_range(1, 50);
                    end
                    2:
                    begin
                        lo = $urandom;
                        hi = lo;
                    end
                    3:
                    begin
                        // Wide span that cannot overflow
                        lo = $urandom >> 1;
                        hi = lo + ($urandom >> 1) + 1;
                    end
                    default:
                    begin
                        lo = $urandom;
                        hi = 32'hffff_ffff;
                    end
                endcase
                add_item(MODE_BOUNDED, $urandom, lo, hi);
                counted++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every item offered and taken, then every result back
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_draws.size() != 0)
            @(posedge clk);
        // Keep watching in case a stray result follows a trailing reseed
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cmwc_pkg.sv
rtl/cmwc_front.sv
rtl/cmwc_queue.sv
rtl/cmwc_divider.sv
rtl/cmwc_back.sv
rtl/cmwc_random_generator.sv
dv/tb_cmwc_random_generator.sv
